// ===== sv/lsfd_pkg.sv =====
// Package for the scan-frame deframer: frame layout constants, codes and shared types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lsfd_pkg;

    localparam int unsigned DATA_START   = 85;
    localparam int unsigned SAMPLE_BYTES = 810;

    localparam int unsigned OFFSET_W  = 17;
    localparam int unsigned INDEX_W   = 10;
    localparam int unsigned RANGE_W   = 16;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned FRAME_W   = 32;
    localparam int unsigned PACKAGE_W = 16;
    localparam int unsigned MAXLEN_W  = 17;

    localparam logic [OFFSET_W-1:0] DATA_LO   = OFFSET_W'(DATA_START);
    localparam logic [OFFSET_W-1:0] DATA_HI   = OFFSET_W'(DATA_START + SAMPLE_BYTES);
    localparam logic                DATA_PAR  = DATA_LO[0];
    localparam logic [INDEX_W-1:0]  SAMPLE_BASE = INDEX_W'((SAMPLE_BYTES / 2) % 1024);

    localparam logic [7:0] SYNC_BYTE = 8'h02;
    localparam logic [7:0] CMD_SCAN  = 8'h73;
    localparam logic [7:0] CMD_SUB_A = 8'h52;
    localparam logic [7:0] CMD_SUB_B = 8'h53;

    localparam logic [OFFSET_W-1:0] OFF_LEN_LAST = OFFSET_W'(7);
    localparam logic [OFFSET_W-1:0] OFF_CMD0     = OFFSET_W'(8);
    localparam logic [OFFSET_W-1:0] OFF_CMD1     = OFFSET_W'(9);
    localparam logic [OFFSET_W-1:0] OFF_FN_FIRST = OFFSET_W'(46);
    localparam logic [OFFSET_W-1:0] OFF_FN_LAST  = OFFSET_W'(49);
    localparam logic [OFFSET_W-1:0] OFF_PKG_HI   = OFFSET_W'(50);
    localparam logic [OFFSET_W-1:0] OFF_PKG_LO   = OFFSET_W'(51);
    localparam logic [OFFSET_W-1:0] OFF_SYNCED   = OFFSET_W'(4);
    localparam logic [OFFSET_W-1:0] MIN_CHK_OFF  = OFFSET_W'(10);
    localparam logic [OFFSET_W-1:0] CHK_BIAS     = OFFSET_W'(8);
    localparam logic [32:0]         TOTAL_BIAS   = 33'd9;

    localparam logic [PACKAGE_W-1:0] PKG_FIRST  = PACKAGE_W'(1);
    localparam logic [PACKAGE_W-1:0] PKG_SECOND = PACKAGE_W'(2);

    localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_COMMAND        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FRAME_MISMATCH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG       = 3'd4;

    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic CFG_MAX_FRAME   = 1'b0;
    localparam logic CFG_RANGE_LIMIT = 1'b1;

    localparam logic [MAXLEN_W-1:0] MAX_FRAME_RESET   = MAXLEN_W'(8192);
    localparam logic [RANGE_W-1:0]  RANGE_LIMIT_RESET = RANGE_W'(25000);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_BODY
    } phase_t;

    typedef struct packed {
        logic                 kind;
        logic [INDEX_W-1:0]   index;
        logic [RANGE_W-1:0]   range_mm;
        logic [STATUS_W-1:0]  status;
        logic [FRAME_W-1:0]   frame_number;
        logic [PACKAGE_W-1:0] package_number;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/lsfd_parser.sv =====
// Frame parser: holds the per-frame state and turns one received byte into at most one result.
// Depends on lsfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsfd_parser (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire logic [7:0]                      rx_byte,
    input  wire logic [lsfd_pkg::MAXLEN_W-1:0]   max_frame_bytes,
    input  wire logic [lsfd_pkg::RANGE_W-1:0]    range_limit_mm,
    output logic                                 emit,
    output lsfd_pkg::result_t                    result
);

    lsfd_pkg::phase_t                    phase_reg, phase_next;
    logic [lsfd_pkg::OFFSET_W-1:0]       offset_reg, offset_next;
    logic [lsfd_pkg::FRAME_W-1:0]        length_reg, length_next;
    logic [lsfd_pkg::OFFSET_W-1:0]       chk_off_reg, chk_off_next;
    logic [7:0]                          xor_reg, xor_next;
    logic                                cmd_reg, cmd_next;
    logic [lsfd_pkg::FRAME_W-1:0]        fn_reg, fn_next;
    logic [lsfd_pkg::PACKAGE_W-1:0]      pkg_reg, pkg_next;
    logic [lsfd_pkg::FRAME_W-1:0]        prev_fn_reg, prev_fn_next;
    logic [7:0]                          high_reg, high_next;
    logic [lsfd_pkg::INDEX_W-1:0]        count_reg, count_next;

    logic [32:0]                         total;
    logic                                in_data;
    logic [lsfd_pkg::RANGE_W-1:0]        mm;

    always_comb
    begin
        phase_next   = phase_reg;
        offset_next  = offset_reg;
        length_next  = length_reg;
        chk_off_next = chk_off_reg;
        xor_next     = xor_reg;
        cmd_next     = cmd_reg;
        fn_next      = fn_reg;
        pkg_next     = pkg_reg;
        prev_fn_next = prev_fn_reg;
        high_next    = high_reg;
        count_next   = count_reg;
        emit         = 1'b0;
        result       = '0;
        total        = {1'b0, length_reg} + lsfd_pkg::TOTAL_BIAS;
        in_data      = 1'b0;
        mm           = '0;

        case (phase_reg)
            lsfd_pkg::PH_HUNT:
            begin
                if (rx_byte == lsfd_pkg::SYNC_BYTE)
                begin
                    if (offset_reg[1:0] == 2'd3)
                    begin
                        phase_next  = lsfd_pkg::PH_LEN;
                        offset_next = lsfd_pkg::OFF_SYNCED;
                        length_next = '0;
                        xor_next    = '0;
                        cmd_next    = 1'b0;
                        fn_next     = '0;
                        pkg_next    = '0;
                        high_next   = '0;
                        count_next  = '0;
                    end
                    else
                    begin
                        offset_next = offset_reg + 1'b1;
                    end
                end
                else
                begin
                    offset_next = '0;
                end
            end

            lsfd_pkg::PH_LEN:
            begin
                length_next = {length_reg[23:0], rx_byte};
                offset_next = offset_reg + 1'b1;
                total       = {1'b0, length_next} + lsfd_pkg::TOTAL_BIAS;
                if (offset_reg == lsfd_pkg::OFF_LEN_LAST)
                begin
                    if (total > {16'b0, max_frame_bytes})
                    begin
                        emit         = 1'b1;
                        result.kind  = lsfd_pkg::KIND_VERDICT;
                        result.status = lsfd_pkg::ST_TOO_LONG;
                        prev_fn_next = '0;
                        phase_next   = lsfd_pkg::PH_HUNT;
                        offset_next  = '0;
                    end
                    else
                    begin
                        phase_next   = lsfd_pkg::PH_BODY;
                        chk_off_next = length_next[lsfd_pkg::OFFSET_W-1:0] + lsfd_pkg::CHK_BIAS;
                    end
                end
            end

            lsfd_pkg::PH_BODY:
            begin
                if (offset_reg >= chk_off_reg)
                begin
                    emit        = 1'b1;
                    result.kind = lsfd_pkg::KIND_VERDICT;
                    if (xor_reg != rx_byte)
                    begin
                        result.status = lsfd_pkg::ST_CHECKSUM;
                    end
                    else if (!cmd_reg || chk_off_reg < lsfd_pkg::MIN_CHK_OFF)
                    begin
                        result.status = lsfd_pkg::ST_COMMAND;
                    end
                    else if (pkg_reg == lsfd_pkg::PKG_SECOND && fn_reg != prev_fn_reg)
                    begin
                        result.status = lsfd_pkg::ST_FRAME_MISMATCH;
                    end
                    else
                    begin
                        result.status = lsfd_pkg::ST_OK;
                        if (pkg_reg == lsfd_pkg::PKG_FIRST)
                        begin
                            prev_fn_next = fn_reg;
                        end
                    end
                    phase_next  = lsfd_pkg::PH_HUNT;
                    offset_next = '0;
                end
                else
                begin
                    xor_next    = xor_reg ^ rx_byte;
                    offset_next = offset_reg + 1'b1;
                    if (offset_reg == lsfd_pkg::OFF_CMD0)
                    begin
                        cmd_next = (rx_byte == lsfd_pkg::CMD_SCAN);
                    end
                    else if (offset_reg == lsfd_pkg::OFF_CMD1)
                    begin
                        cmd_next = cmd_reg && (rx_byte == lsfd_pkg::CMD_SUB_A ||
                                               rx_byte == lsfd_pkg::CMD_SUB_B);
                    end
                    else if (offset_reg >= lsfd_pkg::OFF_FN_FIRST &&
                             offset_reg <= lsfd_pkg::OFF_FN_LAST)
                    begin
                        fn_next = {fn_reg[23:0], rx_byte};
                    end
                    else if (offset_reg == lsfd_pkg::OFF_PKG_HI ||
                             offset_reg == lsfd_pkg::OFF_PKG_LO)
                    begin
                        pkg_next = {pkg_reg[7:0], rx_byte};
                    end

                    in_data = offset_reg >= lsfd_pkg::DATA_LO && offset_reg < lsfd_pkg::DATA_HI;
                    if (in_data)
                    begin
                        if (offset_reg[0] == lsfd_pkg::DATA_PAR)
                        begin
                            high_next = rx_byte;
                        end
                        else if (cmd_next)
                        begin
                            mm = {high_reg, rx_byte};
                            emit          = 1'b1;
                            result.kind   = lsfd_pkg::KIND_SAMPLE;
                            result.status = lsfd_pkg::ST_OK;
                            result.range_mm = (mm >= range_limit_mm) ? '0 : mm;
                            result.index  = count_reg +
                                ((pkg_next == lsfd_pkg::PKG_SECOND) ? lsfd_pkg::SAMPLE_BASE : '0);
                            count_next    = count_reg + 1'b1;
                        end
                    end
                end
            end

            default:
            begin
                phase_next  = lsfd_pkg::PH_HUNT;
                offset_next = '0;
            end
        endcase

        result.frame_number   = fn_next;
        result.package_number = pkg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= lsfd_pkg::PH_HUNT;
            offset_reg  <= '0;
            length_reg  <= '0;
            chk_off_reg <= '0;
            xor_reg     <= '0;
            cmd_reg     <= 1'b0;
            fn_reg      <= '0;
            pkg_reg     <= '0;
            prev_fn_reg <= '0;
            high_reg    <= '0;
            count_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            offset_reg  <= offset_next;
            length_reg  <= length_next;
            chk_off_reg <= chk_off_next;
            xor_reg     <= xor_next;
            cmd_reg     <= cmd_next;
            fn_reg      <= fn_next;
            pkg_reg     <= pkg_next;
            prev_fn_reg <= prev_fn_next;
            high_reg    <= high_next;
            count_reg   <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lidar_scan_frame_deframer_core.sv =====
// Top level of the scan-frame deframer: configuration registers, parser and result register.
// Depends on lsfd_pkg and lsfd_parser.
//
// The block takes one received byte per item on the input channel (in_valid, in_ready,
// rx_byte). It hunts for four sync bytes, follows the length field, and for each frame
// sends range samples as their second byte arrives, then one end-of-frame verdict on the
// output channel (out_valid, out_ready and the result fields). Most bytes give no result.
// A byte is taken every cycle in which in_valid and in_ready are high; its result, if any,
// appears in the result register on the next cycle, through the single pass of parser
// logic between the frame state and the result register.
// While a result waits and out_ready is low, in_ready is low; a new byte is still taken
// in the cycle in which the waiting result is taken.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready:
// index 0 sets the longest accepted frame, index 1 the range limit in millimetres.
// Reset restores both registers to their defaults, clears the result register and puts
// the parser back to hunting for sync with no committed frame number.
`timescale 1ns / 1ps
`default_nettype none

module lidar_scan_frame_deframer_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [7:0]                         rx_byte,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    item_kind,
    output logic [lsfd_pkg::INDEX_W-1:0]            sample_index,
    output logic [lsfd_pkg::RANGE_W-1:0]            range_mm,
    output logic [lsfd_pkg::STATUS_W-1:0]           frame_status,
    output logic [lsfd_pkg::FRAME_W-1:0]            frame_number,
    output logic [lsfd_pkg::PACKAGE_W-1:0]          package_number,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic                               cfg_index,
    input  wire logic [lsfd_pkg::MAXLEN_W-1:0]      cfg_data
);

    logic [lsfd_pkg::MAXLEN_W-1:0] max_frame_reg;
    logic [lsfd_pkg::RANGE_W-1:0]  limit_reg;
    logic                          out_valid_reg;
    lsfd_pkg::result_t             result_reg;
    lsfd_pkg::result_t             result_next;
    logic                          emit;
    logic                          accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg <= lsfd_pkg::MAX_FRAME_RESET;
            limit_reg     <= lsfd_pkg::RANGE_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lsfd_pkg::CFG_MAX_FRAME:   max_frame_reg <= cfg_data;
                lsfd_pkg::CFG_RANGE_LIMIT: limit_reg     <= cfg_data[lsfd_pkg::RANGE_W-1:0];
                default:                   limit_reg     <= limit_reg;
            endcase
        end
    end

    lsfd_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .rx_byte         (rx_byte),
        .max_frame_bytes (max_frame_reg),
        .range_limit_mm  (limit_reg),
        .emit            (emit),
        .result          (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= '0;
        end
        else if (accept && emit)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign item_kind      = result_reg.kind;
    assign sample_index   = result_reg.index;
    assign range_mm       = result_reg.range_mm;
    assign frame_status   = result_reg.status;
    assign frame_number   = result_reg.frame_number;
    assign package_number = result_reg.package_number;

endmodule

`default_nettype wire

// ===== sv/lsfd_checker.sv =====
// Port-level checks for the scan-frame deframer, attached to the top level by a bind.
// Depends on lsfd_pkg and lidar_scan_frame_deframer_core.
`timescale 1ns / 1ps
`default_nettype none

module lsfd_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_ready,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic                               item_kind,
    input  wire logic [lsfd_pkg::INDEX_W-1:0]       sample_index,
    input  wire logic [lsfd_pkg::RANGE_W-1:0]       range_mm,
    input  wire logic [lsfd_pkg::STATUS_W-1:0]      frame_status,
    input  wire logic [lsfd_pkg::FRAME_W-1:0]       frame_number,
    input  wire logic [lsfd_pkg::PACKAGE_W-1:0]     package_number
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(item_kind) &&
            $stable(sample_index) && $stable(range_mm) && $stable(frame_status) &&
            $stable(frame_number) && $stable(package_number))
        else $error("result changed while stalled");

    a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("byte taken while a result is blocked");

    a_sample_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind == lsfd_pkg::KIND_SAMPLE |-> frame_status == lsfd_pkg::ST_OK)
        else $error("sample carries a status");

    a_verdict_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind == lsfd_pkg::KIND_VERDICT |->
            range_mm == '0 && sample_index == '0 && frame_status <= lsfd_pkg::ST_TOO_LONG)
        else $error("verdict fields out of range");

endmodule

bind lidar_scan_frame_deframer_core lsfd_checker u_lsfd_checker (.*);

`default_nettype wire
